// ===== sv/bltl_pkg.sv =====
`default_nettype none

package bltl_pkg;

    // Token kinds as they appear in the token_kind field.
    typedef enum logic [4:0] {
        KIND_INVALID = 5'd0,
        KIND_EOF     = 5'd1,
        KIND_IDENT   = 5'd2,
        KIND_INT     = 5'd3,
        KIND_LBRACE  = 5'd4,
        KIND_RBRACE  = 5'd5,
        KIND_LPAREN  = 5'd6,
        KIND_RPAREN  = 5'd7,
        KIND_COMMA   = 5'd8,
        KIND_SEMI    = 5'd9,
        KIND_EQ      = 5'd10,
        KIND_ADD     = 5'd11,
        KIND_SUB     = 5'd12,
        KIND_MUL     = 5'd13,
        KIND_DIV     = 5'd14,
        KIND_MOD     = 5'd15,
        KIND_EXTRN   = 5'd16,
        KIND_AUTO    = 5'd17
    } kind_t;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic       last;
        logic [7:0] length;
        kind_t      kind;
    } token_t;

    localparam logic [2:0] AUTO_LEN  = 3'd4;
    localparam logic [2:0] EXTRN_LEN = 3'd5;

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        begin
            case (c)
                8'h7B:   k = KIND_LBRACE;
                8'h7D:   k = KIND_RBRACE;
                8'h28:   k = KIND_LPAREN;
                8'h29:   k = KIND_RPAREN;
                8'h2C:   k = KIND_COMMA;
                8'h3B:   k = KIND_SEMI;
                8'h3D:   k = KIND_EQ;
                8'h2B:   k = KIND_ADD;
                8'h2D:   k = KIND_SUB;
                8'h2A:   k = KIND_MUL;
                8'h2F:   k = KIND_DIV;
                8'h25:   k = KIND_MOD;
                default: k = KIND_INVALID;
            endcase
            return k;
        end
    endfunction

    // Character expected at a given position of "auto".
    function automatic logic [7:0] auto_char(input logic [2:0] pos);
        logic [7:0] r;
        begin
            case (pos)
                3'd0:    r = 8'h61;
                3'd1:    r = 8'h75;
                3'd2:    r = 8'h74;
                3'd3:    r = 8'h6F;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    // Character expected at a given position of "extrn".
    function automatic logic [7:0] extrn_char(input logic [2:0] pos);
        logic [7:0] r;
        begin
            case (pos)
                3'd0:    r = 8'h65;
                3'd1:    r = 8'h78;
                3'd2:    r = 8'h74;
                3'd3:    r = 8'h72;
                3'd4:    r = 8'h6E;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/b_language_token_lexer_top.sv =====
// Each result is registered into the output queue when the character that causes it is taken.
// Throughput: one character per clock while the queue has room. A character that both closes
// a word or number and forms a token of its own gives two results, closing token first; the input
// holds s_tready low once three results wait in the four-entry output queue.
// Reset (rst_n, asynchronous, active low) empties the queue and returns the scanner to idle.
`default_nettype none

module b_language_token_lexer_top #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [4:0] token_kind, [12:5] token_length, [15:13] zero
    output logic             m_tlast    // last_of_run
);

    // Width of the running length counter; it must be able to hold MAX_TOKEN_LEN itself.
    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT
    } mode_t;

    typedef enum logic [1:0] {
        CAND_NONE,
        CAND_AUTO,
        CAND_EXTRN
    } cand_t;

    // Scanner state.
    mode_t          mode_reg, mode_next;
    logic [LW-1:0]  run_reg, run_next;
    logic [2:0]     prog_reg, prog_next;
    cand_t          cand_reg, cand_next;

    // Output queue: entry 0 is the one shown on the master port.
    bltl_pkg::token_t q_reg [4];
    bltl_pkg::token_t q_next [4];
    logic [2:0]       count_reg, count_next;

    logic [7:0] ch;
    logic       accept;
    logic       pop;
    logic       is_alpha, is_digit, is_word, is_space;
    logic       closing;
    logic       starts_result;
    bltl_pkg::token_t close_tok, start_tok;
    bltl_pkg::token_t res0, res1;
    logic [1:0] n_res;
    logic [1:0] push_n;
    logic [2:0] rem;
    bltl_pkg::token_t sh [4];
    logic [31:0] len_wide;
    logic [7:0]  shown_len;
    bltl_pkg::kind_t word_kind;

    assign ch     = s_tdata;
    // Room for two more results is guaranteed while at most two wait, so a character
    // that closes a token can follow one that did the same without a gap.
    assign s_tready = (count_reg <= 3'd2);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign pop    = m_tvalid && m_tready;
    assign m_tdata = {3'b000, q_reg[0].length, q_reg[0].kind};
    assign m_tlast = q_reg[0].last;

    // Character classes.
    always_comb
    begin
        is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
        is_digit = (ch >= 8'h30 && ch <= 8'h39);
        is_word  = is_alpha || is_digit || (ch == 8'h5F) || (ch == 8'h2E);
        is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) || (ch == 8'h0D)
                   || (ch == 8'h0C);
    end

    // Length as reported: anything beyond 255 is shown as 255.
    always_comb
    begin
        len_wide  = 32'(run_reg);
        shown_len = (len_wide > 32'd255) ? 8'hFF : len_wide[7:0];
    end

    // An identifier is a keyword only if every character matched and nothing followed.
    always_comb
    begin
        if (cand_reg == CAND_AUTO && prog_reg == bltl_pkg::AUTO_LEN)
        begin
            word_kind = bltl_pkg::KIND_AUTO;
        end
        else if (cand_reg == CAND_EXTRN && prog_reg == bltl_pkg::EXTRN_LEN)
        begin
            word_kind = bltl_pkg::KIND_EXTRN;
        end
        else
        begin
            word_kind = bltl_pkg::KIND_IDENT;
        end
    end

    // Next scanner state and the results this character produces.
    always_comb
    begin
        mode_next = mode_reg;
        run_next  = run_reg;
        prog_next = prog_reg;
        cand_next = cand_reg;
        closing   = 1'b0;
        starts_result = 1'b0;
        close_tok = '{last: 1'b0, length: shown_len, kind: bltl_pkg::KIND_IDENT};
        start_tok = '{last: 1'b0, length: 8'd1, kind: bltl_pkg::KIND_INVALID};

        if (mode_reg == MODE_IDENT && is_word)
        begin
            // The identifier goes on; count it and follow the keyword match.
            if (run_reg < LW'(MAX_TOKEN_LEN))
            begin
                run_next = run_reg + LW'(1);
            end
            if (cand_reg == CAND_AUTO)
            begin
                if (prog_reg < bltl_pkg::AUTO_LEN && ch == bltl_pkg::auto_char(prog_reg))
                begin
                    prog_next = prog_reg + 3'd1;
                end
                else
                begin
                    cand_next = CAND_NONE;
                end
            end
            else if (cand_reg == CAND_EXTRN)
            begin
                if (prog_reg < bltl_pkg::EXTRN_LEN && ch == bltl_pkg::extrn_char(prog_reg))
                begin
                    prog_next = prog_reg + 3'd1;
                end
                else
                begin
                    cand_next = CAND_NONE;
                end
            end
        end
        else if (mode_reg == MODE_INT && is_digit)
        begin
            if (run_reg < LW'(MAX_TOKEN_LEN))
            begin
                run_next = run_reg + LW'(1);
            end
        end
        else
        begin
            // Any open token ends here, then the character is taken on its own.
            if (mode_reg == MODE_IDENT)
            begin
                closing = 1'b1;
                close_tok.kind = word_kind;
            end
            else if (mode_reg == MODE_INT)
            begin
                closing = 1'b1;
                close_tok.kind = bltl_pkg::KIND_INT;
            end
            mode_next = MODE_IDLE;

            if (is_space)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_alpha)
            begin
                mode_next = MODE_IDENT;
                run_next  = LW'(1);
                prog_next = 3'd1;
                if (ch == 8'h61)
                begin
                    cand_next = CAND_AUTO;
                end
                else if (ch == 8'h65)
                begin
                    cand_next = CAND_EXTRN;
                end
                else
                begin
                    cand_next = CAND_NONE;
                end
            end
            else if (is_digit)
            begin
                mode_next = MODE_INT;
                run_next  = LW'(1);
                prog_next = 3'd0;
                cand_next = CAND_NONE;
            end
            else if (ch == 8'h00)
            begin
                starts_result = 1'b1;
                start_tok.kind = bltl_pkg::KIND_EOF;
                start_tok.length = 8'd0;
            end
            else
            begin
                starts_result = 1'b1;
                start_tok.kind = bltl_pkg::single_kind(ch);
            end
        end

        // Order the results and mark the final one of this character.
        start_tok.last = 1'b1;
        if (closing)
        begin
            res0 = close_tok;
            res0.last = !starts_result;
            res1 = start_tok;
            n_res = starts_result ? 2'd2 : 2'd1;
        end
        else
        begin
            res0 = start_tok;
            res1 = start_tok;
            n_res = starts_result ? 2'd1 : 2'd0;
        end
    end

    // Queue update: drop the head if taken, then append this character's results.
    always_comb
    begin
        push_n = accept ? n_res : 2'd0;
        rem    = count_reg - {2'b00, pop};
        sh[0]  = pop ? q_reg[1] : q_reg[0];
        sh[1]  = pop ? q_reg[2] : q_reg[1];
        sh[2]  = pop ? q_reg[3] : q_reg[2];
        sh[3]  = q_reg[3];
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < rem)
            begin
                q_next[i] = sh[i];
            end
            else if (3'(i) == rem)
            begin
                q_next[i] = res0;
            end
            else
            begin
                q_next[i] = res1;
            end
        end
        count_next = rem + {1'b0, push_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            run_reg   <= '0;
            prog_reg  <= 3'd0;
            cand_reg  <= CAND_NONE;
            count_reg <= 3'd0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                run_reg  <= run_next;
                prog_reg <= prog_next;
                cand_reg <= cand_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/b_language_token_lexer_top_tb.sv =====
`default_nettype none

module b_language_token_lexer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 255;

    // Scanner state of the predictor: what kind of token is open.
    typedef enum logic [1:0] {
        SCAN_IDLE  = 2'd0,
        SCAN_IDENT = 2'd1,
        SCAN_INT   = 2'd2
    } scan_t;

    // Keyword that the open identifier may still turn out to be.
    typedef enum logic [1:0] {
        CAND_NONE  = 2'd0,
        CAND_AUTO  = 2'd1,
        CAND_EXTRN = 2'd2
    } cand_t;

    // The scoreboard predicts the tokens that each accepted character causes,
    // keeps them in order, and compares every token that leaves the block
    // against the oldest one still waiting.
    class token_scoreboard;
        bltl_pkg::token_t expected_q[$];
        int     errors;
        scan_t  mode;
        int     run_len;
        int     kw_pos;
        cand_t  cand;
        string  auto_word;
        string  extrn_word;

        function new();
            expected_q.delete();
            errors     = 0;
            mode       = SCAN_IDLE;
            run_len    = 0;
            kw_pos     = 0;
            cand       = CAND_NONE;
            auto_word  = "auto";
            extrn_word = "extrn";
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function void push(input bltl_pkg::kind_t k, input int len);
            bltl_pkg::token_t t;
            t.kind   = k;
            t.length = (len > 255) ? 8'd255 : len[7:0];
            t.last   = 1'b0;
            expected_q.push_back(t);
        endfunction

        function bltl_pkg::kind_t punct_kind(input logic [7:0] c);
            case (c)
                "{":     return bltl_pkg::KIND_LBRACE;
                "}":     return bltl_pkg::KIND_RBRACE;
                "(":     return bltl_pkg::KIND_LPAREN;
                ")":     return bltl_pkg::KIND_RPAREN;
                ",":     return bltl_pkg::KIND_COMMA;
                ";":     return bltl_pkg::KIND_SEMI;
                "=":     return bltl_pkg::KIND_EQ;
                "+":     return bltl_pkg::KIND_ADD;
                "-":     return bltl_pkg::KIND_SUB;
                "*":     return bltl_pkg::KIND_MUL;
                "/":     return bltl_pkg::KIND_DIV;
                "%":     return bltl_pkg::KIND_MOD;
                default: return bltl_pkg::KIND_INVALID;
            endcase
        endfunction

        // The keyword match follows every character of the word, even past
        // the saturation point, so an over-long word can never match.
        function void follow_keyword(input logic [7:0] c);
            if (cand == CAND_AUTO)
            begin
                if (kw_pos < auto_word.len() && c == auto_word[kw_pos])
                    kw_pos++;
                else
                    cand = CAND_NONE;
            end
            else if (cand == CAND_EXTRN)
            begin
                if (kw_pos < extrn_word.len() && c == extrn_word[kw_pos])
                    kw_pos++;
                else
                    cand = CAND_NONE;
            end
        endfunction

        function bltl_pkg::kind_t word_kind();
            if (cand == CAND_AUTO && kw_pos == auto_word.len())
                return bltl_pkg::KIND_AUTO;
            if (cand == CAND_EXTRN && kw_pos == extrn_word.len())
                return bltl_pkg::KIND_EXTRN;
            return bltl_pkg::KIND_IDENT;
        endfunction

        function void note_char(input logic [7:0] c);
            int     size_in;
            bit     letter;
            bit     digit;
            bit     word_char;
            bltl_pkg::token_t t;
            size_in   = expected_q.size();
            letter    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
            digit     = (c >= "0" && c <= "9");
            word_char = letter || digit || c == "_" || c == ".";

            // A character that extends the open token gives nothing yet.
            if (mode == SCAN_IDENT)
            begin
                if (word_char)
                begin
                    if (run_len < MAX_LEN)
                        run_len++;
                    follow_keyword(c);
                    return;
                end
                push(word_kind(), run_len);
            end
            else if (mode == SCAN_INT)
            begin
                if (digit)
                begin
                    if (run_len < MAX_LEN)
                        run_len++;
                    return;
                end
                push(bltl_pkg::KIND_INT, run_len);
            end
            mode = SCAN_IDLE;

            // The closing character is then lexed on its own.
            if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C)
            begin
                // Whitespace makes no token.
            end
            else if (letter)
            begin
                mode    = SCAN_IDENT;
                run_len = 1;
                kw_pos  = 1;
                if (c == "a")
                    cand = CAND_AUTO;
                else if (c == "e")
                    cand = CAND_EXTRN;
                else
                    cand = CAND_NONE;
            end
            else if (digit)
            begin
                mode    = SCAN_INT;
                run_len = 1;
                kw_pos  = 0;
                cand    = CAND_NONE;
            end
            else if (c == 8'h00)
                push(bltl_pkg::KIND_EOF, 0);
            else
                push(punct_kind(c), 1);

            // Only the final token caused by this character carries the mark.
            if (expected_q.size() > size_in)
            begin
                t = expected_q.pop_back();
                t.last = 1'b1;
                expected_q.push_back(t);
            end
        endfunction

        task check_token(input logic [4:0] kind, input logic [7:0] len, input logic last);
            bltl_pkg::token_t t;
            if (expected_q.size() == 0)
            begin
                report($sformatf("token kind %0d len %0d with nothing expected", kind, len));
                return;
            end
            t = expected_q.pop_front();
            if (kind !== t.kind)
                report($sformatf("token_kind %0d, expected %0d", kind, t.kind));
            if (len !== t.length)
                report($sformatf("token_length %0d, expected %0d (kind %0d)",
                                 len, t.length, t.kind));
            if (last !== t.last)
                report($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                                 last, t.last, t.kind));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    token_scoreboard sb;

    // While set, neither side inserts gaps, so the block runs at full rate.
    bit burst;
    // Characters accepted so far.
    int sent;

    b_language_token_lexer_top #(
        .MAX_TOKEN_LEN(MAX_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return rand_letter();
        if (r < 8)
            return rand_digit();
        return (r == 8) ? 8'("_") : 8'(".");
    endfunction

    // Offers one character, holds it until the block takes it, and tells the
    // scoreboard at the edge of acceptance. The task returns in that same
    // time step, so the next call makes the only assignment to s_tvalid.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_char(c);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // A token long enough to drive the length count into saturation.
    task automatic send_long(input bit numeric, input int n);
        send_char(numeric ? rand_digit() : rand_letter());
        for (int i = 1; i < n; i++)
            send_char(numeric ? rand_digit() : rand_word_char());
    endtask

    // One random piece of source text. Most pieces are well-formed tokens so
    // identifiers, numbers and keywords are exercised in every state; plain
    // random bytes and stray end-of-file marks are the noise.
    task automatic send_word();
        string seps;
        string near_kw[11];
        string punct;
        string ws;
        int    r;
        int    n;
        seps    = " \011\012;(),=";
        punct   = "{}(),;=+-*/%";
        ws      = " \011\012\015\014";
        near_kw = '{"aut", "autos", "Auto", "extr", "extrns", "eXtrn", "auto_",
                    "e", "a", "extrn9", "au.to"};
        if ($urandom_range(0, 49) == 0)
            burst = !burst;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            send_text("auto");
            send_char(seps[$urandom_range(0, seps.len() - 1)]);
        end
        else if (r < 20)
        begin
            send_text("extrn");
            send_char(seps[$urandom_range(0, seps.len() - 1)]);
        end
        else if (r < 28)
            send_text(near_kw[$urandom_range(0, 10)]);
        else if (r < 43)
        begin
            n = $urandom_range(0, 7);
            send_char(rand_letter());
            repeat (n) send_char(rand_word_char());
        end
        else if (r < 55)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_char(rand_digit());
        end
        else if (r < 73)
            send_char(punct[$urandom_range(0, punct.len() - 1)]);
        else if (r < 83)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_char(ws[$urandom_range(0, ws.len() - 1)]);
        end
        else if (r < 88)
            send_char(8'h00);
        else if (r < 98)
            send_char(8'($urandom_range(0, 255)));
        else
            send_long(1'($urandom_range(0, 1)), $urandom_range(250, 262));
    endtask

    // The receiving side stalls in runs of random length, except in bursts.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Signals are read just after the edge, before any update made at that
    // edge lands, so the values seen are the ones the block saw.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_token(m_tdata[4:0], m_tdata[12:5], m_tlast);
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        rst_n    = 1'b0;
        burst    = 1'b0;
        sent     = 0;
        sb       = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: keywords, a number running into a letter, numbers
        // cut by underscore and dot, end of file with a token open and twice
        // in a row, high bytes, every kind of whitespace.
        send_text("auto\011extrn(12a_.3 9_8.");
        send_char(8'h00);
        send_char(8'h00);
        send_text("}");
        send_char(8'h80);
        send_char(8'hFF);
        send_text("\015\012\014=x");
        send_char(8'h00);

        // Saturating lengths: one word just past the limit, one number right
        // at it, and a long word that starts out looking like a keyword.
        send_long(1'b0, 256);
        send_char(" ");
        send_long(1'b1, 255);
        send_char(";");
        send_text("auto");
        send_long(1'b0, 260);
        send_char(8'h00);

        while (sent < 1140)
            send_word();
        // Close any open token so its result is also checked.
        send_char(8'h00);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("b_language_token_lexer_top verification clean");
        else
            $display("b_language_token_lexer_top verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("b_language_token_lexer_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
